// ===== hw/rtl/pvalu_pkg.sv =====
// types, constants and helper functions shared by the polar/cartesian vector unit
`timescale 1ns / 1ps
`default_nettype none

package pvalu_pkg;

  // cordic datapath, angle and reduction widths
  localparam int XW = 64;
  localparam int ZW = 40;
  localparam int RW = 49;
  localparam int MOD_CELLS = 13;

  localparam logic signed [ZW-1:0] PI_Z      = 40'sd13493037705;
  localparam logic signed [ZW-1:0] TWO_PI_Z  = 40'sd26986075409;
  localparam logic signed [ZW-1:0] HALF_PI_Z = 40'sd6746518852;
  localparam logic        [RW-1:0] TWO_PI_R  = 49'd26986075409;
  localparam logic        [RW-1:0] MOD_OFS   = 49'd221069929750528;
  localparam logic        [30:0]   GAIN_Q31  = 31'd1304065748;
  localparam logic signed [31:0]   PI_Q16    = 32'sd205887;

  typedef enum logic [3:0] {
    MODE_CADD  = 4'd0,
    MODE_CSUB  = 4'd1,
    MODE_CSCL  = 4'd2,
    MODE_CDOT  = 4'd3,
    MODE_PADD  = 4'd4,
    MODE_PSUB  = 4'd5,
    MODE_PSCL  = 4'd6,
    MODE_PDOT  = 4'd7,
    MODE_TOPOL = 4'd8,
    MODE_TOCAR = 4'd9
  } mode_e;

  typedef struct packed {
    logic        [3:0]  mode;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [15:0] scl;
  } item_t;

  typedef struct packed {
    logic signed [31:0] r0;
    logic signed [31:0] r1;
    logic               ov;
    logic               vec;
    logic               zero;
  } late_t;

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 40'sd3373259426;
      1:  a = 40'sd1991351318;
      2:  a = 40'sd1052175346;
      3:  a = 40'sd534100635;
      4:  a = 40'sd268086748;
      5:  a = 40'sd134174063;
      6:  a = 40'sd67103403;
      7:  a = 40'sd33553749;
      8:  a = 40'sd16777131;
      9:  a = 40'sd8388597;
      10: a = 40'sd4194303;
      default: a = ZW'(64'sd1 <<< (32 - i));
    endcase
    return a;
  endfunction

  // {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [XW-1:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7fffffff};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] rnd_sat(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] t;
    t = (x + 64'sd32768) >>> 16;
    return sat32(t);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pvalu_mod_cell.sv =====
// one restoring subtract step of the angle reduction modulo two pi
`timescale 1ns / 1ps
`default_nettype none

module pvalu_mod_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic                      clk_i,
  input  wire logic [pvalu_pkg::RW-1:0]  v_i,
  output logic      [pvalu_pkg::RW-1:0]  v_o
);

  localparam logic [pvalu_pkg::RW-1:0] SUB = pvalu_pkg::TWO_PI_R << SHIFT;

  logic [pvalu_pkg::RW-1:0] v_d, v_q;

  always_comb begin
    v_d = (v_i >= SUB) ? v_i - SUB : v_i;
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pvalu_cordic_cell.sv =====
// one cordic micro-rotation stage, rotation or vectoring
`timescale 1ns / 1ps
`default_nettype none

module pvalu_cordic_cell #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  wire logic                            clk_i,
  input  wire logic signed [pvalu_pkg::XW-1:0] x_i,
  input  wire logic signed [pvalu_pkg::XW-1:0] y_i,
  input  wire logic signed [pvalu_pkg::ZW-1:0] z_i,
  output logic      signed [pvalu_pkg::XW-1:0] x_o,
  output logic      signed [pvalu_pkg::XW-1:0] y_o,
  output logic      signed [pvalu_pkg::ZW-1:0] z_o
);

  localparam logic signed [pvalu_pkg::ZW-1:0] ANG = pvalu_pkg::atan_step(STAGE);

  logic signed [pvalu_pkg::XW-1:0] dx, dy;
  logic signed [pvalu_pkg::XW-1:0] x_d, y_d, x_q, y_q;
  logic signed [pvalu_pkg::ZW-1:0] z_d, z_q;
  logic                            up;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    up = VECTOR ? y_i[pvalu_pkg::XW-1] : !z_i[pvalu_pkg::ZW-1];
    if (up) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ANG;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

// ===== hw/rtl/polar_cartesian_vector_alu.sv =====
// top level: pipelined polar/cartesian vector unit built from cordic cell chains
//
// channel   direction  handshake          word
// command   in         start_i, busy_o    mode_i, a_*_i, b_*_i, scale_factor_i
// result    out        done_o strobe      res_first_o, res_second_o, overflow_o
//
// one word accepted every cycle; busy_o stays low
// from accept to done_o a word passes the angle reduction chain and the rotation
//   and vectoring cordic chains in series
// reset clears only the valid line; words in flight are dropped
// done_o lasts one cycle and cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

module polar_cartesian_vector_alu #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic        [3:0]  mode_i,
  input  wire logic signed [31:0] a_first_i,
  input  wire logic signed [31:0] a_second_i,
  input  wire logic signed [31:0] b_first_i,
  input  wire logic signed [31:0] b_second_i,
  input  wire logic signed [15:0] scale_factor_i,
  output logic                    done_o,
  output logic signed [31:0]      res_first_o,
  output logic signed [31:0]      res_second_o,
  output logic                    overflow_o
);

  localparam int N     = CORDIC_STAGES;
  localparam int XW    = pvalu_pkg::XW;
  localparam int ZW    = pvalu_pkg::ZW;
  localparam int RW    = pvalu_pkg::RW;
  localparam int MC    = pvalu_pkg::MOD_CELLS;
  localparam int SBL   = 16 + N;
  localparam int VLAST = 20 + 2 * N;
  localparam int LAT   = VLAST + 1;

  // valid line
  logic [VLAST:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLAST-1:0], start_i};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[VLAST];

  // command sideband
  pvalu_pkg::item_t sb_q [SBL];

  always_ff @(posedge clk_i) begin
    sb_q[0] <= '{mode: mode_i, a0: a_first_i, a1: a_second_i, b0: b_first_i,
                 b1: b_second_i, scl: scale_factor_i};
    for (int j = 1; j < SBL; j++) begin
      sb_q[j] <= sb_q[j-1];
    end
  end

  // angle reduction chains
  logic        [RW-1:0] av [MC+1];
  logic        [RW-1:0] bv [MC+1];
  logic signed [RW:0]   ext_a, ext_b;

  always_comb begin
    ext_a = {{2{sb_q[0].a1[31]}}, sb_q[0].a1, 16'h0000};
    ext_b = {{2{sb_q[0].b1[31]}}, sb_q[0].b1, 16'h0000};
    av[0] = sb_q[0].a1[31] ? ext_a[RW-1:0] + pvalu_pkg::MOD_OFS : ext_a[RW-1:0];
    bv[0] = sb_q[0].b1[31] ? ext_b[RW-1:0] + pvalu_pkg::MOD_OFS : ext_b[RW-1:0];
  end

  for (genvar j = 0; j < MC; j++) begin : g_mod
    pvalu_mod_cell #(.SHIFT(MC - 1 - j)) u_mod_a (.clk_i(clk_i), .v_i(av[j]), .v_o(av[j+1]));
    pvalu_mod_cell #(.SHIFT(MC - 1 - j)) u_mod_b (.clk_i(clk_i), .v_i(bv[j]), .v_o(bv[j+1]));
  end

  // fold into half plane and scale radius by the gain
  function automatic logic [ZW:0] fold_f(input logic [RW-1:0] v);
    logic signed [ZW-1:0] z;
    logic                 neg;
    z   = signed'(v[ZW-1:0]);
    neg = 1'b0;
    if (z > pvalu_pkg::PI_Z) begin
      z = z - pvalu_pkg::TWO_PI_Z;
    end
    if (z > pvalu_pkg::HALF_PI_Z) begin
      z   = z - pvalu_pkg::PI_Z;
      neg = 1'b1;
    end else if (z < -pvalu_pkg::HALF_PI_Z) begin
      z   = z + pvalu_pkg::PI_Z;
      neg = 1'b1;
    end
    return {neg, z};
  endfunction

  localparam logic signed [31:0] GAIN_S = signed'({1'b0, pvalu_pkg::GAIN_Q31});

  logic [ZW:0]            fa, fb;
  logic signed [32:0]     ra, rb;
  logic signed [XW-1:0]   fold_pa_d, fold_pb_d, fold_pa_q, fold_pb_q;
  logic signed [ZW-1:0]   fold_za_q, fold_zb_q;

  always_comb begin
    fa = fold_f(av[MC]);
    fb = fold_f(bv[MC]);
    ra = fa[ZW] ? -33'(sb_q[MC].a0) : 33'(sb_q[MC].a0);
    rb = fb[ZW] ? -33'(sb_q[MC].b0) : 33'(sb_q[MC].b0);
    fold_pa_d = XW'(ra * GAIN_S);
    fold_pb_d = XW'(rb * GAIN_S);
  end

  always_ff @(posedge clk_i) begin
    fold_pa_q <= fold_pa_d;
    fold_pb_q <= fold_pb_d;
    fold_za_q <= signed'(fa[ZW-1:0]);
    fold_zb_q <= signed'(fb[ZW-1:0]);
  end

  // rotation chains
  logic signed [XW-1:0] rax [N+1];
  logic signed [XW-1:0] ray [N+1];
  logic signed [ZW-1:0] raz [N+1];
  logic signed [XW-1:0] rbx [N+1];
  logic signed [XW-1:0] rby [N+1];
  logic signed [ZW-1:0] rbz [N+1];

  assign rax[0] = fold_pa_q >>> 15;
  assign ray[0] = '0;
  assign raz[0] = fold_za_q;
  assign rbx[0] = fold_pb_q >>> 15;
  assign rby[0] = '0;
  assign rbz[0] = fold_zb_q;

  for (genvar i = 0; i < N; i++) begin : g_rot
    pvalu_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_rot_a (
      .clk_i(clk_i), .x_i(rax[i]), .y_i(ray[i]), .z_i(raz[i]),
      .x_o(rax[i+1]), .y_o(ray[i+1]), .z_o(raz[i+1])
    );
    pvalu_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_rot_b (
      .clk_i(clk_i), .x_i(rbx[i]), .y_i(rby[i]), .z_i(rbz[i]),
      .x_o(rbx[i+1]), .y_o(rby[i+1]), .z_o(rbz[i+1])
    );
  end

  // round rotation outputs
  logic [32:0]        rnd_a0, rnd_a1, rnd_b0, rnd_b1;
  logic [3:0]         rnd_mode;
  logic               rnd_ov_d;
  logic signed [31:0] ca0_q, ca1_q, cb0_q, cb1_q;
  logic               rnd_ov_q;

  always_comb begin
    rnd_a0   = pvalu_pkg::rnd_sat(rax[N]);
    rnd_a1   = pvalu_pkg::rnd_sat(ray[N]);
    rnd_b0   = pvalu_pkg::rnd_sat(rbx[N]);
    rnd_b1   = pvalu_pkg::rnd_sat(rby[N]);
    rnd_mode = sb_q[14+N].mode;
    rnd_ov_d = 1'b0;
    if (rnd_mode == pvalu_pkg::MODE_PADD || rnd_mode == pvalu_pkg::MODE_PSUB ||
        rnd_mode == pvalu_pkg::MODE_PDOT) begin
      rnd_ov_d = rnd_a0[32] | rnd_a1[32] | rnd_b0[32] | rnd_b1[32];
    end else if (rnd_mode == pvalu_pkg::MODE_PSCL || rnd_mode == pvalu_pkg::MODE_TOCAR) begin
      rnd_ov_d = rnd_a0[32] | rnd_a1[32];
    end
  end

  always_ff @(posedge clk_i) begin
    ca0_q    <= signed'(rnd_a0[31:0]);
    ca1_q    <= signed'(rnd_a1[31:0]);
    cb0_q    <= signed'(rnd_b0[31:0]);
    cb1_q    <= signed'(rnd_b1[31:0]);
    rnd_ov_q <= rnd_ov_d;
  end

  // cartesian operation, products and sums
  pvalu_pkg::item_t     op_it;
  logic                 polar, scl;
  logic signed [31:0]   oa0, oa1, ob0, ob1, mb0, mb1;
  logic signed [32:0]   s0_d, s1_d, s0_q, s1_q;
  logic signed [XW-1:0] m0_d, m1_d, m0_q, m1_q;
  logic [3:0]           op_mode_q;
  logic                 op_ov_q;

  always_comb begin
    op_it = sb_q[15+N];
    polar = op_it.mode[3:2] == 2'b01;
    scl   = op_it.mode == pvalu_pkg::MODE_CSCL || op_it.mode == pvalu_pkg::MODE_PSCL;
    oa0   = polar ? ca0_q : op_it.a0;
    oa1   = polar ? ca1_q : op_it.a1;
    ob0   = polar ? cb0_q : op_it.b0;
    ob1   = polar ? cb1_q : op_it.b1;
    mb0   = scl ? 32'(op_it.scl) : ob0;
    mb1   = scl ? 32'(op_it.scl) : ob1;
    m0_d  = XW'(oa0 * mb0);
    m1_d  = XW'(oa1 * mb1);
    if (op_it.mode == pvalu_pkg::MODE_CSUB || op_it.mode == pvalu_pkg::MODE_PSUB) begin
      s0_d = 33'(oa0) - 33'(ob0);
      s1_d = 33'(oa1) - 33'(ob1);
    end else if (op_it.mode == pvalu_pkg::MODE_TOPOL) begin
      s0_d = 33'(op_it.a0);
      s1_d = 33'(op_it.a1);
    end else if (op_it.mode == pvalu_pkg::MODE_TOCAR) begin
      s0_d = 33'(ca0_q);
      s1_d = 33'(ca1_q);
    end else begin
      s0_d = 33'(oa0) + 33'(ob0);
      s1_d = 33'(oa1) + 33'(ob1);
    end
  end

  always_ff @(posedge clk_i) begin
    m0_q      <= m0_d;
    m1_q      <= m1_d;
    s0_q      <= s0_d;
    s1_q      <= s1_d;
    op_mode_q <= op_it.mode;
    op_ov_q   <= rnd_ov_q;
  end

  // saturate operation result
  logic [32:0]          q0, q1;
  logic signed [XW-1:0] dsum;
  pvalu_pkg::late_t     late_d;
  pvalu_pkg::late_t     late_q [N+3];

  always_comb begin
    dsum   = XW'((65'(m0_q) + 65'(m1_q)) >>> 16);
    q0     = '0;
    q1     = '0;
    late_d = '0;
    unique case (op_mode_q)
      pvalu_pkg::MODE_CADD, pvalu_pkg::MODE_CSUB, pvalu_pkg::MODE_PADD,
      pvalu_pkg::MODE_PSUB, pvalu_pkg::MODE_TOPOL, pvalu_pkg::MODE_TOCAR: begin
        q0 = pvalu_pkg::sat32(XW'(s0_q));
        q1 = pvalu_pkg::sat32(XW'(s1_q));
      end
      pvalu_pkg::MODE_CSCL, pvalu_pkg::MODE_PSCL: begin
        q0 = pvalu_pkg::sat32(m0_q);
        q1 = pvalu_pkg::sat32(m1_q);
      end
      pvalu_pkg::MODE_CDOT, pvalu_pkg::MODE_PDOT: begin
        q0 = pvalu_pkg::sat32(dsum);
      end
      default: begin
        q0 = '0;
      end
    endcase
    late_d.r0   = signed'(q0[31:0]);
    late_d.r1   = signed'(q1[31:0]);
    late_d.ov   = op_ov_q | q0[32] | q1[32];
    late_d.vec  = op_mode_q == pvalu_pkg::MODE_PADD || op_mode_q == pvalu_pkg::MODE_PSUB ||
                  op_mode_q == pvalu_pkg::MODE_PSCL || op_mode_q == pvalu_pkg::MODE_TOPOL;
    late_d.zero = q0[31:0] == 32'h0 && q1[31:0] == 32'h0;
  end

  always_ff @(posedge clk_i) begin
    late_q[0] <= late_d;
    for (int j = 1; j < N + 3; j++) begin
      late_q[j] <= late_q[j-1];
    end
  end

  // vectoring set-up
  logic signed [XW-1:0] px, py, vx0_d, vy0_d, vx0_q, vy0_q;
  logic signed [ZW-1:0] vz0_d, vz0_q;

  always_comb begin
    px    = XW'(late_q[0].r0) <<< 16;
    py    = XW'(late_q[0].r1) <<< 16;
    vx0_d = px;
    vy0_d = py;
    vz0_d = '0;
    if (px < 0) begin
      vz0_d = (py >= 0) ? pvalu_pkg::PI_Z : -pvalu_pkg::PI_Z;
      vx0_d = -px;
      vy0_d = -py;
    end
  end

  always_ff @(posedge clk_i) begin
    vx0_q <= vx0_d;
    vy0_q <= vy0_d;
    vz0_q <= vz0_d;
  end

  // vectoring chain
  logic signed [XW-1:0] vx [N+1];
  logic signed [XW-1:0] vy [N+1];
  logic signed [ZW-1:0] vz [N+1];

  assign vx[0] = vx0_q;
  assign vy[0] = vy0_q;
  assign vz[0] = vz0_q;

  for (genvar i = 0; i < N; i++) begin : g_vec
    pvalu_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_vec (
      .clk_i(clk_i), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1])
    );
  end

  // gain compensation partial products and angle wrap
  logic [46:0]          plo_q;
  logic [47:0]          ph0_q, ph1_q;
  logic signed [ZW-1:0] gz_d, gz_q;

  always_comb begin
    gz_d = vz[N];
    if (gz_d > pvalu_pkg::PI_Z) begin
      gz_d = gz_d - pvalu_pkg::TWO_PI_Z;
    end
    if (gz_d <= -pvalu_pkg::PI_Z) begin
      gz_d = gz_d + pvalu_pkg::TWO_PI_Z;
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q <= 47'(vx[N][15:0]) * 47'(pvalu_pkg::GAIN_Q31);
    ph0_q <= 48'(vx[N][32:16]) * 48'(pvalu_pkg::GAIN_Q31);
    ph1_q <= 48'(vx[N][49:33]) * 48'(pvalu_pkg::GAIN_Q31);
    gz_q  <= gz_d;
  end

  // final sum, rounding and output register
  logic [65:0]          gt;
  logic [34:0]          grad;
  logic signed [ZW-1:0] gang;
  logic signed [31:0]   res0_d, res1_d, res0_q, res1_q;
  logic                 ov_d, ov_q, out_vec_q, out_zero_q;
  pvalu_pkg::late_t     lt;

  always_comb begin
    lt     = late_q[N+2];
    gt     = (66'(ph1_q) << 17) + 66'(ph0_q) + 66'(plo_q >> 16);
    grad   = 35'((gt + 66'(64'd1 << 30)) >> 31);
    gang   = (gz_q + 40'sd32768) >>> 16;
    res0_d = lt.r0;
    res1_d = lt.r1;
    ov_d   = lt.ov;
    if (lt.vec) begin
      if (lt.zero) begin
        res0_d = '0;
        res1_d = '0;
      end else begin
        res0_d = (grad > 35'd2147483647) ? 32'sh7fffffff : signed'(grad[31:0]);
        res1_d = signed'(gang[31:0]);
        ov_d   = lt.ov | (grad > 35'd2147483647);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res0_q     <= res0_d;
    res1_q     <= res1_d;
    ov_q       <= ov_d;
    out_vec_q  <= lt.vec && !lt.zero;
    out_zero_q <= lt.vec && lt.zero;
  end

  assign res_first_o  = res0_q;
  assign res_second_o = res1_q;
  assign overflow_o   = ov_q;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("accepted word did not complete after the pipeline latency");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_zero_q |-> res_first_o == 32'sd0 && res_second_o == 32'sd0)
    else $error("zero vector did not give zero radius and angle");

  a_angle_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_vec_q |->
      res_second_o <= pvalu_pkg::PI_Q16 && res_second_o >= -pvalu_pkg::PI_Q16)
    else $error("polar angle out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_polar_cartesian_vector_alu.sv =====
// testbench for the polar/cartesian vector unit: directed and random words checked against a predictor
`timescale 1ns / 1ps

module tb_polar_cartesian_vector_alu;

  localparam int STAGES = 16;
  localparam int LATENCY = 21 + 2 * STAGES;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM = 780;
  localparam logic [3:0] MODE_SPARE_LO = 4'd10;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;
  localparam longint PI_U = 64'sd13493037705;
  localparam longint TWO_PI_U = 64'sd26986075409;
  localparam longint HALF_PI_U = 64'sd6746518852;
  localparam longint GAIN = 64'sd1304065748;
  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] res_first;
    logic signed [31:0] res_second;
    logic               ovf;
  } vec_result_t;

  class vector_scoreboard;
    vec_result_t pending[$];
    int errors = 0;

    function longint clamp(longint v, inout bit ov);
      if (v > Q16_MAX) begin
        ov = 1;
        return Q16_MAX;
      end
      if (v < Q16_MIN) begin
        ov = 1;
        return Q16_MIN;
      end
      return v;
    endfunction

    function longint arctan(int i);
      longint tbl[11] = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346,
                          64'sd534100635, 64'sd268086748, 64'sd134174063,
                          64'sd67103403, 64'sd33553749, 64'sd16777131,
                          64'sd8388597, 64'sd4194303};
      if (i < 11) return tbl[i];
      return 64'sd1 <<< (32 - i);
    endfunction

    function void rotate(longint r, longint phi, output longint xo, output longint yo,
                         inout bit ov);
      longint z, x, y, dx, dy;
      z = (phi * 65536) % TWO_PI_U;
      if (z < 0) z += TWO_PI_U;
      if (z > PI_U) z -= TWO_PI_U;
      if (z > HALF_PI_U) begin
        z -= PI_U;
        r = -r;
      end else if (z < -HALF_PI_U) begin
        z += PI_U;
        r = -r;
      end
      x = (r * GAIN) >>> 15;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan(i);
        end else begin
          x += dx; y -= dy; z += arctan(i);
        end
      end
      xo = clamp((x + 32768) >>> 16, ov);
      yo = clamp((y + 32768) >>> 16, ov);
    endfunction

    function void vectorise(longint xq, longint yq, output longint ro, output longint ao,
                            inout bit ov);
      longint x, y, z, dx, dy, hi, lo, t;
      ro = 0;
      ao = 0;
      if (xq == 0 && yq == 0) return;
      x = xq * 65536;
      y = yq * 65536;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_U : -PI_U;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x -= dx; y += dy; z -= arctan(i);
        end else begin
          x += dx; y -= dy; z += arctan(i);
        end
      end
      if (z > PI_U) z -= TWO_PI_U;
      if (z <= -PI_U) z += TWO_PI_U;
      hi = x >>> 16;
      lo = x & 64'shFFFF;
      t = hi * GAIN + ((lo * GAIN) >>> 16);
      ro = clamp((t + (64'sd1 <<< 30)) >>> 31, ov);
      ao = (z + 32768) >>> 16;
    endfunction

    function void cart_apply(logic [1:0] op, longint ax, longint ay, longint bx, longint by,
                             longint s, output longint r0, output longint r1, inout bit ov);
      longint p1, p2;
      case (op)
        2'd0: begin
          r0 = clamp(ax + bx, ov);
          r1 = clamp(ay + by, ov);
        end
        2'd1: begin
          r0 = clamp(ax - bx, ov);
          r1 = clamp(ay - by, ov);
        end
        2'd2: begin
          r0 = clamp(ax * s, ov);
          r1 = clamp(ay * s, ov);
        end
        default: begin
          p1 = ax * bx;
          p2 = ay * by;
          r0 = clamp((p1 >>> 16) + (p2 >>> 16) +
                     (((p1 & 64'shFFFF) + (p2 & 64'shFFFF)) >>> 16), ov);
          r1 = 0;
        end
      endcase
    endfunction

    function void note(logic [3:0] mode, logic signed [31:0] a0, logic signed [31:0] a1,
                       logic signed [31:0] b0, logic signed [31:0] b1,
                       logic signed [15:0] scl);
      longint ax, ay, bx, by, r0, r1;
      bit ov;
      vec_result_t e;
      ov = 0;
      r0 = 0;
      r1 = 0;
      bx = 0;
      by = 0;
      if (mode <= pvalu_pkg::MODE_CDOT) begin
        cart_apply(mode[1:0], a0, a1, b0, b1, scl, r0, r1, ov);
      end else if (mode <= pvalu_pkg::MODE_PDOT) begin
        rotate(a0, a1, ax, ay, ov);
        if (mode != pvalu_pkg::MODE_PSCL) rotate(b0, b1, bx, by, ov);
        cart_apply(mode[1:0], ax, ay, bx, by, scl, r0, r1, ov);
        if (mode != pvalu_pkg::MODE_PDOT) vectorise(r0, r1, r0, r1, ov);
      end else if (mode == pvalu_pkg::MODE_TOPOL) begin
        vectorise(a0, a1, r0, r1, ov);
      end else if (mode == pvalu_pkg::MODE_TOCAR) begin
        rotate(a0, a1, r0, r1, ov);
      end
      e.res_first = r0[31:0];
      e.res_second = r1[31:0];
      e.ovf = ov;
      pending.push_back(e);
    endfunction

    function void check(logic signed [31:0] r0, logic signed [31:0] r1, logic ov);
      vec_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word r0=%0d r1=%0d ov=%0b", $time, r0, r1, ov);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r0 !== e.res_first) begin
        $display("%0t: res_first expected %0d actual %0d", $time, e.res_first, r0);
        errors++;
      end
      if (r1 !== e.res_second) begin
        $display("%0t: res_second expected %0d actual %0d", $time, e.res_second, r1);
        errors++;
      end
      if (ov !== e.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, ov);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic [3:0] mode_i = '0;
  logic signed [31:0] a_first_i = '0;
  logic signed [31:0] a_second_i = '0;
  logic signed [31:0] b_first_i = '0;
  logic signed [31:0] b_second_i = '0;
  logic signed [15:0] scale_factor_i = '0;
  logic busy_o, done_o, overflow_o;
  logic signed [31:0] res_first_o, res_second_o;

  vector_scoreboard sb = new();
  int idle_cycles = 0;

  polar_cartesian_vector_alu #(.CORDIC_STAGES(STAGES)) u_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      sb.note(mode_i, a_first_i, a_second_i, b_first_i, b_second_i, scale_factor_i);
    if (rst_ni && done_o) sb.check(res_first_o, res_second_o, overflow_o);
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(logic [3:0] m, logic signed [31:0] a0, logic signed [31:0] a1,
                           logic signed [31:0] b0, logic signed [31:0] b1,
                           logic signed [15:0] s);
    @(negedge clk_i);
    start_i = 1;
    mode_i = m;
    a_first_i = a0;
    a_second_i = a1;
    b_first_i = b0;
    b_second_i = b1;
    scale_factor_i = s;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(int n);
    @(negedge clk_i);
    start_i = 0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic random_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return;
    if (k < 95) pause($urandom_range(0, 3));
    else pause($urandom_range(20, 70));
  endtask

  function automatic logic signed [31:0] pick32();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      4: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
      default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
    endcase
  endfunction

  function automatic logic signed [15:0] pick16();
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  initial begin
    logic [3:0] m;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // extremes and each operation
    send_word(pvalu_pkg::MODE_CADD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 16'sd0);
    send_word(pvalu_pkg::MODE_CSUB, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 16'sd0);
    send_word(pvalu_pkg::MODE_CSCL, 32'sh00010000, -32'sh00020000, 0, 0, 16'sh7fff);
    send_word(pvalu_pkg::MODE_CSCL, 32'sh7fffffff, 32'sh80000000, 0, 0, 16'sh8000);
    send_word(pvalu_pkg::MODE_CDOT, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 16'sd1);
    send_word(pvalu_pkg::MODE_CDOT, 32'sh00018000, -32'sh00004000, 32'sh00020000,
              32'sh00030000, 0);
    send_word(pvalu_pkg::MODE_PADD, 32'sh00010000, 32'sh0001921f, 32'sh00010000,
              -32'sh0001921f, 0);
    send_word(pvalu_pkg::MODE_PSUB, 32'sh00020000, 32'sh00000000, 32'sh00020000,
              32'sh00000000, 0);
    send_word(pvalu_pkg::MODE_PSCL, -32'sh00030000, 32'sh00008000, 32'sh7fffffff,
              32'sh7fffffff, 16'sd3);
    send_word(pvalu_pkg::MODE_PDOT, 32'sh00040000, 32'sh7fffffff, 32'sh00020000,
              32'sh80000000, 0);
    send_word(pvalu_pkg::MODE_PADD, 32'sh7fffffff, 32'sh00000000, 32'sh7fffffff,
              32'sh00000000, 0);
    send_word(pvalu_pkg::MODE_TOPOL, 0, 0, 32'sh12345678, 32'sh1, 0);
    send_word(pvalu_pkg::MODE_TOPOL, -32'sh00010000, 0, 0, 0, 0);
    send_word(pvalu_pkg::MODE_TOPOL, -32'sh00010000, -32'sh1, 0, 0, 0);
    send_word(pvalu_pkg::MODE_TOPOL, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
    send_word(pvalu_pkg::MODE_TOPOL, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    send_word(pvalu_pkg::MODE_TOCAR, 32'sh7fffffff, 32'sh00006488, 0, 0, 0);
    send_word(pvalu_pkg::MODE_TOCAR, -32'sh00010000, 32'sh7fffffff, 0, 0, 0);
    send_word(pvalu_pkg::MODE_TOCAR, 32'sh00010000, 32'sh80000000, 0, 0, 0);
    send_word(pvalu_pkg::MODE_TOCAR, 32'sh00010000, 32'sh00032440, 0, 0, 0);
    send_word(MODE_SPARE_LO, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
    send_word(MODE_SPARE_HI, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1);

    // hold off until the pipe drains
    @(negedge clk_i);
    start_i = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 19) == 0) m = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else m = 4'($urandom_range(pvalu_pkg::MODE_CADD, pvalu_pkg::MODE_TOCAR));
      send_word(m, pick32(), pick32(), pick32(), pick32(), pick16());
      if ((n % 200) < 40) random_gap();
      else if ((n % 200) > 120) random_gap();
    end

    @(negedge clk_i);
    start_i = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/pvalu_pkg.sv
hw/rtl/pvalu_mod_cell.sv
hw/rtl/pvalu_cordic_cell.sv
hw/rtl/polar_cartesian_vector_alu.sv
tb/sv/tb_polar_cartesian_vector_alu.sv
